// ----- hw/rtl/wbs_pkg.sv -----
// Shared constants and types for the brightness sweep block.
package wbs_pkg;

	localparam int MAX_PANELS_DEF = 30;
	localparam logic [15:0] DUR_RESET = 16'd1000;
	localparam logic [7:0]  WW_RESET  = 8'd4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_PANEL_COUNT = 3'd0,
		REG_DURATION    = 3'd1,
		REG_WAVE_WIDTH  = 3'd2,
		REG_ADDR0       = 3'd3,
		REG_ADDR1       = 3'd4,
		REG_ADDR2       = 3'd5,
		REG_ADDR3       = 3'd6
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // latch the tick time
		logic load;      // start time and elapsed time
		logic prep;      // per-tick products
		logic eval;      // distance for the current panel
		logic div_step;  // one quotient bit
		logic cmp;       // compare with stored level, load command
		logic adv;       // next panel
		logic fin;       // update done flag, load status item
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;      // sweep already finished
		logic at_end;    // all panels walked
		logic zero;      // current panel is dark, no division
		logic div_last;  // final quotient bit
		logic changed;   // level differs from stored one
	} dp_stat_t;

endpackage

// ----- hw/rtl/wave_brightness_sweep.sv -----
// Top level of the brightness sweep: controller plus datapath.
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_ready   now_ms
// out      from block out_valid / out_ready send_valid, panel_index, panel_address,
//                                           brightness, finished, last_of_run
// cfg      to block   cfg_we                cfg_index, cfg_data
//
// One tick transaction at a time. Setup runs accept, load and prep in turn, then
// each panel is evaluated; a lit panel also runs the 8-bit restoring divider, one
// quotient bit per cycle, and a panel whose level changed sends a command item
// once out_ready is high. The end check, status load and status item come last.
// A finished sweep goes from load straight to the status load and status item.
// Reset clears config to defaults, the stored levels, start and done flags.
// A stalled out transaction holds the controller; in_ready is low meanwhile.
module wave_brightness_sweep import wbs_pkg::*; #(
	parameter int MAX_PANELS = MAX_PANELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        send_valid,
	output logic [4:0]  panel_index,
	output logic [7:0]  panel_address,
	output logic [7:0]  brightness,
	output logic        finished,
	output logic        last_of_run,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing: tick, per-panel evaluate/divide/compare, status item
	wbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic in units of 1/(2*duration); payload registers live here
	wbs_dp #(.MAX_PANELS(MAX_PANELS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.now_ms        (now_ms),
		.cmd           (cmd),
		.stat          (stat),
		.send_valid    (send_valid),
		.panel_index   (panel_index),
		.panel_address (panel_address),
		.brightness    (brightness),
		.finished      (finished),
		.last_of_run   (last_of_run)
	);

endmodule

// ----- hw/rtl/wbs_ctrl.sv -----
// Controller state machine for the brightness sweep.
module wbs_ctrl import wbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LOAD = 9'b000000010,
		ST_PREP = 9'b000000100,
		ST_EVAL = 9'b000001000,
		ST_DIV  = 9'b000010000,
		ST_CMP  = 9'b000100000,
		ST_SEND = 9'b001000000,
		ST_FIN  = 9'b010000000,
		ST_SOUT = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = stat.done ? ST_FIN : ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.at_end) begin
					state_d = ST_FIN;
				end else begin
					cmd.eval = 1'b1;
					state_d  = stat.zero ? ST_CMP : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				if (stat.changed) begin
					state_d = ST_SEND;
				end else begin
					cmd.adv = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_SEND: begin
				if (out_ready) begin
					cmd.adv = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_SOUT;
			end
			ST_SOUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SEND) || (state_q == ST_SOUT);

endmodule

// ----- hw/rtl/wbs_dp.sv -----
// Datapath: config registers, level store, distance and serial divider.
module wbs_dp import wbs_pkg::*; #(
	parameter int MAX_PANELS = MAX_PANELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [31:0] now_ms,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic        send_valid,
	output logic [4:0]  panel_index,
	output logic [7:0]  panel_address,
	output logic [7:0]  brightness,
	output logic        finished,
	output logic        last_of_run
);

	localparam int IW = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;

	logic [4:0]  pcount_q;
	logic [15:0] dur_q;
	logic [7:0]  ww_q;
	logic [63:0] addr_q [4];

	logic [7:0]  last_q [MAX_PANELS];
	logic [31:0] now_q, start_q, elapsed_q;
	logic        started_q, done_q;
	logic [38:0] ctr_q;
	logic [23:0] half_q;
	logic [22:0] pos_q;
	logic [4:0]  i_q;
	logic [31:0] rem_q;
	logic [7:0]  quo_q;
	logic [2:0]  k_q;

	logic [4:0]  cnt_sat;
	logic [38:0] pos_x, gap;
	logic [23:0] diff;
	logic [31:0] trial;
	logic [7:0]  stored;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= '0;
			dur_q    <= DUR_RESET;
			ww_q     <= WW_RESET;
			for (int a = 0; a < 4; a++) addr_q[a] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PANEL_COUNT: pcount_q  <= cfg_data[4:0];
				REG_DURATION:    dur_q     <= cfg_data[15:0];
				REG_WAVE_WIDTH:  ww_q      <= cfg_data[7:0];
				REG_ADDR0:       addr_q[0] <= cfg_data;
				REG_ADDR1:       addr_q[1] <= cfg_data;
				REG_ADDR2:       addr_q[2] <= cfg_data;
				REG_ADDR3:       addr_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt_sat = ({1'b0, pcount_q} > 6'(MAX_PANELS)) ? 5'(MAX_PANELS) : pcount_q;
	assign pos_x   = {16'b0, pos_q};
	assign gap     = (pos_x >= ctr_q) ? (pos_x - ctr_q) : (ctr_q - pos_x);
	assign diff    = half_q - gap[23:0];
	assign trial   = {8'b0, half_q} << k_q;
	assign stored  = last_q[i_q[IW-1:0]];

	assign stat.done     = done_q;
	assign stat.at_end   = (i_q >= cnt_sat);
	assign stat.zero     = (half_q == '0) || (gap >= {15'b0, half_q});
	assign stat.div_last = (k_q == '0);
	assign stat.changed  = (quo_q != stored);

	// sequence state and level store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			for (int p = 0; p < MAX_PANELS; p++) last_q[p] <= '0;
		end else begin
			if (cmd.load && !done_q && !started_q) begin
				start_q   <= now_q;
				started_q <= 1'b1;
			end
			if (cmd.cmp && stat.changed) last_q[i_q[IW-1:0]] <= quo_q;
			if (cmd.fin && (elapsed_q >= {16'b0, dur_q})) done_q <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.take) now_q <= now_ms;
		if (cmd.load) elapsed_q <= started_q ? (now_q - start_q) : '0;
		if (cmd.prep) begin
			ctr_q  <= {32'b0, cnt_sat + 6'd2, 1'b0} * {7'b0, elapsed_q};
			half_q <= 24'(ww_q) * 24'(dur_q);
			pos_q  <= 23'(dur_q) + 23'({dur_q, 1'b0});
			i_q    <= '0;
		end
		if (cmd.eval) begin
			quo_q <= '0;
			k_q   <= 3'd7;
			rem_q <= ({8'b0, diff} << 8) - {8'b0, diff};
		end
		if (cmd.div_step) begin
			if (rem_q >= trial) begin
				rem_q      <= rem_q - trial;
				quo_q[k_q] <= 1'b1;
			end
			k_q <= k_q - 3'd1;
		end
		if (cmd.adv) begin
			i_q   <= i_q + 5'd1;
			pos_q <= pos_q + 23'({dur_q, 1'b0});
		end
		if (cmd.cmp) begin
			send_valid    <= 1'b1;
			panel_index   <= i_q;
			panel_address <= addr_q[i_q[4:3]][{i_q[2:0], 3'b000} +: 8];
			brightness    <= quo_q;
			finished      <= 1'b0;
			last_of_run   <= 1'b0;
		end
		if (cmd.fin) begin
			send_valid    <= 1'b0;
			panel_index   <= '0;
			panel_address <= '0;
			brightness    <= '0;
			finished      <= done_q || (elapsed_q >= {16'b0, dur_q});
			last_of_run   <= 1'b1;
		end
	end

endmodule

// ----- hw/rtl/wbs_checker.sv -----
// Port-level checks for the brightness sweep, bound to the top level.
module wbs_props (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       send_valid,
	input logic [4:0] panel_index,
	input logic [7:0] panel_address,
	input logic [7:0] brightness,
	input logic       finished,
	input logic       last_of_run
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(brightness) && $stable(panel_index))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid |->
		last_of_run && panel_index == 5'd0 && panel_address == 8'd0 && brightness == 8'd0)
		else $error("malformed status item");

	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid |-> !finished && !last_of_run)
		else $error("malformed command item");

endmodule

bind wave_brightness_sweep wbs_props u_wbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.send_valid    (send_valid),
	.panel_index   (panel_index),
	.panel_address (panel_address),
	.brightness    (brightness),
	.finished      (finished),
	.last_of_run   (last_of_run)
);
